>>> hdl/gsa_pkg.sv
// ----------------------------------------------------------------------------
// Generational slot allocator package
// Opcodes, status codes, field widths and the controller/datapath link types.
// ----------------------------------------------------------------------------
package gsa_pkg;

   localparam int OPCODE_W = 2;
   localparam int HIDX_W   = 16;
   localparam int HGEN_W   = 16;
   localparam int STATUS_W = 2;
   localparam int SIDX_W   = 8;
   localparam int SGEN_W   = 16;
   localparam int FREED_W  = 9;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOC   = 2'd0,
      OP_CHECK   = 2'd1,
      OP_DESTROY = 2'd2,
      OP_COMMIT  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_NO_FREE = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_CLEAR,
      DP_ACCEPT,
      DP_GEN_RD,
      DP_ALLOC_WR,
      DP_ALLOC_FAIL,
      DP_CHECK,
      DP_DESTROY,
      DP_COMMIT_STEP,
      DP_COMMIT_RES
   } dp_action_type;

   typedef struct packed {
      dp_action_type action;
   } dp_cmd_type;

   typedef struct packed {
      logic   clear_last;
      logic   free_empty;
      logic   commit_done;
      logic   res_free;
      op_type op;
   } dp_stat_type;

endpackage

>>> hdl/gsa_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one allocator operation per transfer.
// ----------------------------------------------------------------------------
interface gsa_req_if import gsa_pkg::*;;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [HIDX_W-1:0]   handle_index;
   logic [HGEN_W-1:0]   handle_generation;

   modport source (output valid, opcode, handle_index, handle_generation, input ready);
   modport sink   (input valid, opcode, handle_index, handle_generation, output ready);
endinterface

>>> hdl/gsa_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one allocator result per transfer.
// ----------------------------------------------------------------------------
interface gsa_rsp_if import gsa_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SIDX_W-1:0]   slot_index;
   logic [SGEN_W-1:0]   slot_generation;
   logic [FREED_W-1:0]  freed_count;

   modport source (output valid, status, slot_index, slot_generation, freed_count,
                   input ready);
   modport sink   (input valid, status, slot_index, slot_generation, freed_count,
                   output ready);
endinterface

>>> hdl/gsa_ctrl.sv
// ----------------------------------------------------------------------------
// Generational slot allocator controller
// Sequences the clearing pass, request dispatch and the commit walk.
// ----------------------------------------------------------------------------
module gsa_ctrl import gsa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_ALLOC_WR,
      S_COMMIT
   } state_type;

   state_type     state_ff, state_in;
   logic          ready_ff, ready_in;
   dp_action_type action;

   always_comb begin
      state_in = state_ff;
      action   = DP_NONE;
      unique case (state_ff)
         S_CLEAR: begin
            action = DP_CLEAR;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid && ready_ff) begin
               action   = DP_ACCEPT;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.op)
               OP_ALLOC: begin
                  if (!stat.free_empty) begin
                     action   = DP_GEN_RD;
                     state_in = S_ALLOC_WR;
                  end else if (stat.res_free) begin
                     action   = DP_ALLOC_FAIL;
                     state_in = S_IDLE;
                  end
               end
               OP_CHECK: begin
                  if (stat.res_free) begin
                     action   = DP_CHECK;
                     state_in = S_IDLE;
                  end
               end
               OP_DESTROY: begin
                  if (stat.res_free) begin
                     action   = DP_DESTROY;
                     state_in = S_IDLE;
                  end
               end
               OP_COMMIT: begin
                  action   = DP_COMMIT_STEP;
                  state_in = S_COMMIT;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_ALLOC_WR: begin
            if (stat.res_free) begin
               action   = DP_ALLOC_WR;
               state_in = S_IDLE;
            end
         end
         S_COMMIT: begin
            if (!stat.commit_done) begin
               action = DP_COMMIT_STEP;
            end else if (stat.res_free) begin
               action   = DP_COMMIT_RES;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      ready_in = (state_in == S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready  = ready_ff;
   assign cmd.action = action;

endmodule

>>> hdl/gsa_dp.sv
// ----------------------------------------------------------------------------
// Generational slot allocator datapath
// Free stack, generation table, pending queue, counters and result register.
// ----------------------------------------------------------------------------
module gsa_dp import gsa_pkg::*; #(
   parameter int SLOT_COUNT = 256,
   parameter int GEN_BITS   = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_stat_type         stat,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [HIDX_W-1:0]   req_handle_index,
   input  logic [HGEN_W-1:0]   req_handle_generation,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SIDX_W-1:0]   rsp_slot_index,
   output logic [SGEN_W-1:0]   rsp_slot_generation,
   output logic [FREED_W-1:0]  rsp_freed_count
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);

   // Bit GEN_BITS of a generation entry is the live flag.
   logic [IDX_W-1:0]  stack_mem [SLOT_COUNT];
   logic [GEN_BITS:0] gen_mem   [SLOT_COUNT];
   logic [IDX_W-1:0]  pend_mem  [SLOT_COUNT];

   logic [IDX_W-1:0]  stack_rd_ff;
   logic [GEN_BITS:0] gen_rd_ff;
   logic [IDX_W-1:0]  pend_rd_ff;

   logic [CNT_W-1:0]    free_count_ff, free_count_in;
   logic [CNT_W-1:0]    pend_count_ff, pend_count_in;
   logic [CNT_W-1:0]    cmt_idx_ff, cmt_idx_in;
   logic                cmt_rd_v_ff, cmt_rd_v_in;
   logic [IDX_W-1:0]    clr_addr_ff, clr_addr_in;
   op_type              op_ff, op_in;
   logic [HIDX_W-1:0]   idx_ff, idx_in;
   logic [GEN_BITS-1:0] hgen_ff, hgen_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff, status_in;
   logic [SIDX_W-1:0]   sidx_ff, sidx_in;
   logic [SGEN_W-1:0]   sgen_ff, sgen_in;
   logic [FREED_W-1:0]  freed_ff, freed_in;

   dp_action_type       act;
   logic                res_free;
   logic                load_res;
   logic                idx_in_range;
   logic                handle_ok;
   logic                destroy_ok;
   logic                cmt_more;
   logic                cmt_push;
   logic [GEN_BITS+HGEN_W-1:0] hgen_ext;
   logic [IDX_W+SIDX_W-1:0]    sidx_ext;
   logic [GEN_BITS+SGEN_W-1:0] sgen_ext;
   logic [CNT_W+FREED_W-1:0]   freed_ext;

   logic              stack_re, stack_we;
   logic [IDX_W-1:0]  stack_raddr, stack_waddr, stack_wdata;
   logic              gen_re, gen_we;
   logic [IDX_W-1:0]  gen_raddr, gen_waddr;
   logic [GEN_BITS:0] gen_wdata;
   logic              pend_re, pend_we;
   logic [IDX_W-1:0]  pend_raddr, pend_waddr, pend_wdata;

   assign act          = cmd.action;
   assign res_free     = !rsp_valid_ff || rsp_ready;
   assign idx_in_range = {1'b0, idx_ff} < (HIDX_W + 1)'(SLOT_COUNT);
   assign handle_ok    = idx_in_range && gen_rd_ff[GEN_BITS] &&
                         (gen_rd_ff[GEN_BITS-1:0] == hgen_ff);
   assign destroy_ok   = (act == DP_DESTROY) && handle_ok;
   assign cmt_more     = cmt_idx_ff < pend_count_ff;
   assign cmt_push     = (act == DP_COMMIT_STEP) && cmt_rd_v_ff;
   assign load_res     = (act == DP_ALLOC_WR) || (act == DP_ALLOC_FAIL) ||
                         (act == DP_CHECK) || (act == DP_DESTROY) ||
                         (act == DP_COMMIT_RES);

   assign hgen_ext  = {{GEN_BITS{1'b0}}, req_handle_generation};
   assign sidx_ext  = {{SIDX_W{1'b0}}, slot_ff};
   assign sgen_ext  = {{SGEN_W{1'b0}}, gen_rd_ff[GEN_BITS-1:0]};
   assign freed_ext = {{FREED_W{1'b0}}, pend_count_ff};

   // Memory port control.
   always_comb begin
      stack_re    = (act == DP_ACCEPT);
      stack_raddr = IDX_W'(free_count_ff - CNT_W'(1));
      stack_we    = (act == DP_CLEAR) || cmt_push;
      stack_waddr = (act == DP_CLEAR) ? clr_addr_ff : free_count_ff[IDX_W-1:0];
      stack_wdata = (act == DP_CLEAR) ? clr_addr_ff : pend_rd_ff;

      gen_re    = (act == DP_ACCEPT) || (act == DP_GEN_RD);
      gen_raddr = (act == DP_ACCEPT) ? req_handle_index[IDX_W-1:0] : stack_rd_ff;
      gen_we    = (act == DP_CLEAR) || (act == DP_ALLOC_WR) || destroy_ok;
      case (act)
         DP_CLEAR: begin
            gen_waddr = clr_addr_ff;
            gen_wdata = '0;
         end
         DP_ALLOC_WR: begin
            gen_waddr = slot_ff;
            gen_wdata = {1'b1, gen_rd_ff[GEN_BITS-1:0]};
         end
         default: begin
            gen_waddr = idx_ff[IDX_W-1:0];
            gen_wdata = {1'b0, gen_rd_ff[GEN_BITS-1:0] + GEN_BITS'(1)};
         end
      endcase

      pend_re    = (act == DP_COMMIT_STEP) && cmt_more;
      pend_raddr = cmt_idx_ff[IDX_W-1:0];
      pend_we    = destroy_ok;
      pend_waddr = pend_count_ff[IDX_W-1:0];
      pend_wdata = idx_ff[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
      if (stack_re) stack_rd_ff <= stack_mem[stack_raddr];
   end

   always_ff @(posedge clock) begin
      if (gen_we) gen_mem[gen_waddr] <= gen_wdata;
      if (gen_re) gen_rd_ff <= gen_mem[gen_raddr];
   end

   always_ff @(posedge clock) begin
      if (pend_we) pend_mem[pend_waddr] <= pend_wdata;
      if (pend_re) pend_rd_ff <= pend_mem[pend_raddr];
   end

   // Next values of counters, request capture and the result register.
   always_comb begin
      free_count_in = free_count_ff;
      pend_count_in = pend_count_ff;
      cmt_idx_in    = cmt_idx_ff;
      cmt_rd_v_in   = (act == DP_COMMIT_STEP) && cmt_more;
      clr_addr_in   = clr_addr_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      hgen_in       = hgen_ff;
      slot_in       = slot_ff;
      status_in     = status_ff;
      sidx_in       = sidx_ff;
      sgen_in       = sgen_ff;
      freed_in      = freed_ff;

      if (act == DP_CLEAR) clr_addr_in = clr_addr_ff + IDX_W'(1);
      if (act == DP_ACCEPT) begin
         op_in      = op_type'(req_opcode);
         idx_in     = req_handle_index;
         hgen_in    = hgen_ext[GEN_BITS-1:0];
         cmt_idx_in = '0;
      end
      if (act == DP_GEN_RD) begin
         free_count_in = free_count_ff - CNT_W'(1);
         slot_in       = stack_rd_ff;
      end
      if (pend_re) cmt_idx_in = cmt_idx_ff + CNT_W'(1);
      if (cmt_push) free_count_in = free_count_ff + CNT_W'(1);
      if (destroy_ok) pend_count_in = pend_count_ff + CNT_W'(1);
      if (act == DP_COMMIT_RES) pend_count_in = '0;

      if (load_res) begin
         status_in = ST_OK;
         sidx_in   = '0;
         sgen_in   = '0;
         freed_in  = '0;
         case (act)
            DP_ALLOC_FAIL: status_in = ST_NO_FREE;
            DP_ALLOC_WR: begin
               sidx_in = sidx_ext[SIDX_W-1:0];
               sgen_in = sgen_ext[SGEN_W-1:0];
            end
            DP_COMMIT_RES: freed_in = freed_ext[FREED_W-1:0];
            default: begin
               if (!handle_ok) status_in = ST_INVALID;
            end
         endcase
      end

      if (load_res) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff <= CNT_W'(SLOT_COUNT);
         pend_count_ff <= '0;
         cmt_idx_ff    <= '0;
         cmt_rd_v_ff   <= 1'b0;
         clr_addr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         free_count_ff <= free_count_in;
         pend_count_ff <= pend_count_in;
         cmt_idx_ff    <= cmt_idx_in;
         cmt_rd_v_ff   <= cmt_rd_v_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      idx_ff    <= idx_in;
      hgen_ff   <= hgen_in;
      slot_ff   <= slot_in;
      status_ff <= status_in;
      sidx_ff   <= sidx_in;
      sgen_ff   <= sgen_in;
      freed_ff  <= freed_in;
   end

   assign stat.clear_last  = (clr_addr_ff == IDX_W'(SLOT_COUNT - 1));
   assign stat.free_empty  = (free_count_ff == '0);
   assign stat.commit_done = !cmt_more && !cmt_rd_v_ff;
   assign stat.res_free    = res_free;
   assign stat.op          = op_ff;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_slot_index      = sidx_ff;
   assign rsp_slot_generation = sgen_ff;
   assign rsp_freed_count     = freed_ff;

`ifndef NO_ASSERTIONS
   a_free_count_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= CNT_W'(SLOT_COUNT))
      else $error("free count exceeds the slot count");

   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      load_res |-> res_free)
      else $error("result loaded while the previous one is still held");

   a_popped_slot_not_live: assert property (@(posedge clock) disable iff (reset)
      (act == DP_ALLOC_WR) |-> !gen_rd_ff[GEN_BITS])
      else $error("slot taken from the free stack is already live");

   a_push_follows_read: assert property (@(posedge clock) disable iff (reset)
      cmt_rd_v_ff |-> $past(pend_re))
      else $error("commit push without a pending queue read");
`endif

endmodule

>>> hdl/generational_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// Generational slot allocator
// Hands out slot handles with per-slot generations; destroyed slots wait in
// a pending queue until a commit returns them to the free stack.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  req_ch    in         opcode, handle_index, handle_generation
//  rsp_ch    out        status, slot_index, slot_generation, freed_count
//
// Check and destroy read the generation table once; allocate reads the stack,
// then the generation table; commit walks the N pending slots, one slot per
// cycle through the pending queue read port.
// After reset a clearing pass over all SLOT_COUNT entries loads the free
// stack and zeroes the generation table; no request is taken meanwhile.
// A result sits in an output register; the next request is taken while it
// waits, and only its final step stalls until the register is free.
module generational_slot_allocator_top import gsa_pkg::*; #(
   parameter int SLOT_COUNT = 256,
   parameter int GEN_BITS   = 16
) (
   input  logic       clock,
   input  logic       reset,
   gsa_req_if.sink    req_ch,
   gsa_rsp_if.source  rsp_ch
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   gsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gsa_dp #(
      .SLOT_COUNT (SLOT_COUNT),
      .GEN_BITS   (GEN_BITS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_opcode            (req_ch.opcode),
      .req_handle_index      (req_ch.handle_index),
      .req_handle_generation (req_ch.handle_generation),
      .rsp_ready             (rsp_ch.ready),
      .rsp_valid             (rsp_ch.valid),
      .rsp_status            (rsp_ch.status),
      .rsp_slot_index        (rsp_ch.slot_index),
      .rsp_slot_generation   (rsp_ch.slot_generation),
      .rsp_freed_count       (rsp_ch.freed_count)
   );

endmodule
